/* hw/rtl/hsk_pkg.sv */
// ----------------------------------------------------------------------------
// hsk_pkg
// Shared types, codes and defaults for the streaming histogram sketch.
// ----------------------------------------------------------------------------
package hsk_pkg;

  localparam int DEF_MAX_CENTROIDS = 64;
  localparam int DEF_VALUE_WIDTH   = 32;

  // item kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUANT = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  // Q1.16 one
  localparam logic [16:0] FRAC_ONE = 17'd65536;

  localparam int DIV_NW = 64;
  localparam int DIV_DW = 34;

  typedef struct packed {
    logic signed [31:0] value;
    logic [31:0]        count;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

/* hw/rtl/hsk_if.sv */
// ----------------------------------------------------------------------------
// hsk_if
// Item, result and register-write channels of the histogram sketch.
// ----------------------------------------------------------------------------
interface hsk_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] value;
  logic [15:0]        weight;
  logic [16:0]        fraction;

  modport source (output valid, output kind, output value, output weight,
                  output fraction, input ready);
  modport sink   (input valid, input kind, input value, input weight,
                  input fraction, output ready);
endinterface

interface hsk_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        total_count;
  logic signed [31:0] quantile_value;
  logic [31:0]        count_estimate;
  logic [1:0]         status;

  modport source (output valid, output total_count, output quantile_value,
                  output count_estimate, output status, input ready);
  modport sink   (input valid, input total_count, input quantile_value,
                  input count_estimate, input status, output ready);
endinterface

interface hsk_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/hsk_store.sv */
// ----------------------------------------------------------------------------
// hsk_store
// Centroid table: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hsk_store
  import hsk_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_CENTROIDS + 1,
  parameter int AW    = $clog2(DEF_MAX_CENTROIDS + 1)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/hsk_div.sv */
// ----------------------------------------------------------------------------
// hsk_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hsk_div
  import hsk_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNTW = $clog2(DIV_NW + 1);

  logic              busy;
  logic [CNTW-1:0]   cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den;
  logic [DIV_NW-1:0] quo;
  logic              done;
  logic [DIV_DW:0]   trial;

  assign trial = {rem, quo[DIV_NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      den <= req.den;
      quo <= req.num;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= DIV_DW'(trial - {1'b0, den});
        quo <= {quo[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

/* hw/rtl/hsk_sqrt.sv */
// ----------------------------------------------------------------------------
// hsk_sqrt
// Integer square root of a 64-bit word, one result bit per cycle.
// ----------------------------------------------------------------------------
module hsk_sqrt
  import hsk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [63:0] x;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = r + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= req.radicand;
      r    <= '0;
      bitv <= 64'd1 << 62;
    end else if (busy) begin
      if (x >= trial) begin
        x <= x - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign rsp.done = done;
  assign rsp.root = r[31:0];

endmodule

/* hw/rtl/streaming_histogram_sketch.sv */
// ----------------------------------------------------------------------------
// streaming_histogram_sketch
// Streaming histogram of Q16.16 values kept as a sorted centroid table.
// ----------------------------------------------------------------------------
// One item is worked on at a time; a finished result sits in the output
// register while the next item is taken. The centroid table lives in one
// single-port-style memory (one read, one write per cycle, read data
// registered), so every table walk takes a read state and a check or write
// state per entry. An add walks to its slot and then shifts the later
// entries up to open a gap; when the table overflows, a gap scan, a merge
// through the divider and a close-up follow. A quantile query walks to its
// bucket, then runs normalising shifts, a square root and a division; a
// count query walks to its bucket, then runs a division and multiply steps.
// The table needs no clearing after reset: only entries below the fill count
// are ever read. Register writes go to max_centroids, clamped to
// 1..MAX_CENTROIDS, and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module streaming_histogram_sketch
  import hsk_pkg::*;
#(
  parameter int MAX_CENTROIDS = DEF_MAX_CENTROIDS,
  parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH
) (
  input logic         clk,
  input logic         rst,
  hsk_req_if.sink     req,
  hsk_rsp_if.source   rsp,
  hsk_cfg_if.sink     cfg
);

  // values wider than 32 bits are handled as 32
  localparam int CAP   = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam int SHV   = 32 - CAP;
  localparam int DEPTH = MAX_CENTROIDS + 1;
  localparam int AW    = $clog2(MAX_CENTROIDS + 1);
  localparam int CW    = $clog2(MAX_CENTROIDS + 2);
  localparam logic signed [31:0] VMIN_RST = 32'((64'd1 << (CAP - 1)) - 64'd1);
  localparam logic signed [31:0] VMAX_RST = 32'(~((64'd1 << (CAP - 1)) - 64'd1));
  localparam int MAXC_RST = (MAX_CENTROIDS < 64) ? MAX_CENTROIDS : 64;

  typedef enum logic [39:0] {
    S_IDLE   = 40'd1 << 0,
    S_START  = 40'd1 << 1,
    S_A_RD   = 40'd1 << 2,
    S_A_CHK  = 40'd1 << 3,
    S_SH_RD  = 40'd1 << 4,
    S_SH_WR  = 40'd1 << 5,
    S_OV     = 40'd1 << 6,
    S_G_RD   = 40'd1 << 7,
    S_G_CHK  = 40'd1 << 8,
    S_M_RLO  = 40'd1 << 9,
    S_M_LO   = 40'd1 << 10,
    S_M_HI   = 40'd1 << 11,
    S_M_MUL  = 40'd1 << 12,
    S_M_DST  = 40'd1 << 13,
    S_M_DIV  = 40'd1 << 14,
    S_M_WB   = 40'd1 << 15,
    S_SD_RD  = 40'd1 << 16,
    S_SD_WR  = 40'd1 << 17,
    S_Q_RD   = 40'd1 << 18,
    S_Q_CHK  = 40'd1 << 19,
    S_Q_PREP = 40'd1 << 20,
    S_Q_SH   = 40'd1 << 21,
    S_Q_M1   = 40'd1 << 22,
    S_Q_M2   = 40'd1 << 23,
    S_Q_DISC = 40'd1 << 24,
    S_Q_SQ   = 40'd1 << 25,
    S_Q_DEN  = 40'd1 << 26,
    S_Q_DIV  = 40'd1 << 27,
    S_Q_LERP = 40'd1 << 28,
    S_Q_FIN  = 40'd1 << 29,
    S_C_RD   = 40'd1 << 30,
    S_C_CHK  = 40'd1 << 31,
    S_C_SPAN = 40'd1 << 32,
    S_C_DIV  = 40'd1 << 33,
    S_C_M1   = 40'd1 << 34,
    S_C_M2   = 40'd1 << 35,
    S_C_M3   = 40'd1 << 36,
    S_C_EST  = 40'd1 << 37,
    S_C_FIN  = 40'd1 << 38,
    S_DONE   = 40'd1 << 39
  } state_t;

  state_t state;

  // sketch state
  logic [CW-1:0]      n;
  logic [CW-1:0]      maxc;
  logic [31:0]        total;
  logic signed [31:0] vmin;
  logic signed [31:0] vmax;

  // current item
  logic [1:0]         kind_r;
  logic signed [31:0] v_r;
  logic [15:0]        w_r;
  logic [16:0]        frac_r;

  // walk and arithmetic registers
  logic [CW-1:0]      k;
  logic [CW-1:0]      j;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      bidx;
  logic signed [31:0] lv;
  logic [31:0]        lc;
  logic signed [31:0] hv;
  logic [31:0]        hc;
  logic [63:0]        s;
  logic [63:0]        tq;
  logic signed [31:0] gprev;
  logic [32:0]        gbest;
  logic [63:0]        qc;
  logic [63:0]        qa;
  logic [63:0]        qd;
  logic               qneg;
  logic               qazero;
  logic               sneg;
  logic [63:0]        m1;
  logic [63:0]        m2;
  logic [32:0]        den;
  logic [63:0]        prod;
  logic [32:0]        ssum;
  logic [31:0]        off;
  logic [16:0]        xz;

  // result being built
  logic signed [31:0] res_qv;
  logic [31:0]        res_cnt;
  logic [1:0]         res_st;

  // output register
  logic               o_valid;
  logic [31:0]        o_total;
  logic signed [31:0] o_qv;
  logic [31:0]        o_cnt;
  logic [1:0]         o_st;

  // table port
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  // datapath helpers
  logic signed [31:0] vin;
  logic [32:0]        cnt_add;
  logic [31:0]        cnt_sat;
  logic [32:0]        tot_add;
  logic [16:0]        frac_c;
  logic [63:0]        qsum;
  logic [32:0]        gap;
  logic [CW-1:0]      jm1;
  logic [CW-1:0]      jp1;
  logic [CW-1:0]      bidx1;
  logic signed [32:0] adiff;
  logic [32:0]        aabs;
  logic signed [32:0] span;
  logic [32:0]        span_abs;
  logic [32:0]        cnum;
  logic [63:0]        twoad;
  logic [63:0]        disc;
  logic [64:0]        est_rnd;
  logic [33:0]        qoff;
  logic               load_out;

  hsk_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  hsk_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  hsk_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  // sign-extend the incoming value from its configured width
  assign vin     = $signed(req.value << SHV) >>> SHV;
  assign cnt_add = {1'b0, rd_data.count} + {17'b0, w_r};
  assign cnt_sat = cnt_add[32] ? 32'hFFFF_FFFF : cnt_add[31:0];
  assign tot_add = {1'b0, total} + {17'b0, w_r};
  assign frac_c  = (frac_r > FRAC_ONE) ? FRAC_ONE : frac_r;
  // running sum plus this half count plus the previous half count
  assign qsum    = s + {17'b0, rd_data.count, 15'b0} + {17'b0, lc, 15'b0};
  assign gap     = 33'({rd_data.value[31], rd_data.value} - {gprev[31], gprev});
  assign jm1     = j - CW'(1);
  assign jp1     = j + CW'(1);
  assign bidx1   = bidx + CW'(1);
  assign adiff   = $signed({1'b0, hc}) - $signed({1'b0, lc});
  assign aabs    = adiff[32] ? 33'(-adiff) : adiff;
  assign span    = $signed({hv[31], hv}) - $signed({lv[31], lv});
  assign span_abs = span[32] ? 33'(-span) : span;
  assign cnum    = (v_r > lv) ? 33'($signed({v_r[31], v_r}) - $signed({lv[31], lv})) : '0;
  assign twoad   = {m2[62:0], 1'b0};
  assign disc    = qneg ? ((m1 > twoad) ? (m1 - twoad) : '0) : (m1 + twoad);
  assign est_rnd = {1'b0, s} + 65'd32768;
  assign qoff    = prod[49:16];
  assign load_out = (state == S_DONE) && (!o_valid || rsp.ready);

  // table, divider and root requests
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = k[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = k[AW-1:0];
    wr_data  = rd_data;
    div_req  = '{start: 1'b0, num: '0, den: '0};
    sqrt_req = '{start: 1'b0, radicand: disc};
    case (state)
      S_A_RD, S_Q_RD, S_C_RD: begin
        rd_en = (k != n);
      end
      S_A_CHK: begin
        if (rd_data.value == v_r) begin
          wr_en   = 1'b1;
          wr_data = '{value: rd_data.value, count: cnt_sat};
        end
      end
      S_SH_RD: begin
        if (j == pos) begin
          wr_en   = 1'b1;
          wr_addr = pos[AW-1:0];
          wr_data = '{value: v_r, count: {16'b0, w_r}};
        end else begin
          rd_en   = 1'b1;
          rd_addr = jm1[AW-1:0];
        end
      end
      S_SH_WR, S_SD_WR: begin
        wr_en   = 1'b1;
        wr_addr = j[AW-1:0];
      end
      S_G_RD: begin
        rd_en = 1'b1;
      end
      S_M_RLO: begin
        rd_en   = 1'b1;
        rd_addr = bidx[AW-1:0];
      end
      S_M_LO: begin
        rd_en   = 1'b1;
        rd_addr = bidx1[AW-1:0];
      end
      S_M_DST: begin
        div_req = '{start: 1'b1, num: prod, den: {1'b0, ssum}};
      end
      S_M_WB: begin
        wr_en   = 1'b1;
        wr_addr = bidx[AW-1:0];
        wr_data = '{value: lv + $signed(off),
                    count: ssum[32] ? 32'hFFFF_FFFF : ssum[31:0]};
      end
      S_SD_RD: begin
        if ({1'b0, jp1} < {1'b0, n}) begin
          rd_en   = 1'b1;
          rd_addr = jp1[AW-1:0];
        end
      end
      S_Q_DISC: begin
        sqrt_req.start = 1'b1;
      end
      S_Q_DEN: begin
        if (den != '0) begin
          // (2D) << 16 over the trapezoid root term
          div_req = '{start: 1'b1, num: {qd[46:0], 17'b0}, den: {1'b0, den}};
        end
      end
      S_C_SPAN: begin
        if (!span[32] && span != '0) begin
          div_req = '{start: 1'b1, num: {15'b0, cnum, 16'b0}, den: {1'b0, span}};
        end
      end
      default: begin
      end
    endcase
  end

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      maxc <= CW'(MAXC_RST);
    end else if (cfg.valid) begin
      if (cfg.data == '0) begin
        maxc <= CW'(1);
      end else if (32'(cfg.data) > MAX_CENTROIDS) begin
        maxc <= CW'(MAX_CENTROIDS);
      end else begin
        maxc <= CW'(cfg.data);
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      total <= '0;
      vmin  <= VMIN_RST;
      vmax  <= VMAX_RST;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_START;
          end
        end
        S_START: begin
          case (kind_r)
            KIND_ADD: begin
              if (w_r == '0) begin
                state <= S_DONE;
              end else begin
                if (v_r < vmin) vmin <= v_r;
                if (v_r > vmax) vmax <= v_r;
                total <= tot_add[32] ? 32'hFFFF_FFFF : tot_add[31:0];
                state <= S_A_RD;
              end
            end
            KIND_QUANT: begin
              state <= (n == '0) ? S_DONE : S_Q_RD;
            end
            KIND_COUNT: begin
              if (n == '0 || v_r >= vmax || v_r < vmin) begin
                state <= S_DONE;
              end else begin
                state <= S_C_RD;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_A_RD: begin
          state <= (k == n) ? S_SH_RD : S_A_CHK;
        end
        S_A_CHK: begin
          if (rd_data.value == v_r) begin
            state <= S_DONE;
          end else if (rd_data.value > v_r) begin
            state <= S_SH_RD;
          end else begin
            state <= S_A_RD;
          end
        end
        S_SH_RD: begin
          if (j == pos) begin
            n     <= n + CW'(1);
            state <= S_OV;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: state <= S_SH_RD;
        S_OV: begin
          state <= (n > maxc) ? S_G_RD : S_DONE;
        end
        S_G_RD:  state <= S_G_CHK;
        S_G_CHK: state <= (k == n - CW'(1)) ? S_M_RLO : S_G_RD;
        S_M_RLO: state <= S_M_LO;
        S_M_LO:  state <= S_M_HI;
        S_M_HI:  state <= S_M_MUL;
        S_M_MUL: state <= S_M_DST;
        S_M_DST: state <= S_M_DIV;
        S_M_DIV: begin
          if (div_rsp.done) state <= S_M_WB;
        end
        S_M_WB:  state <= S_SD_RD;
        S_SD_RD: begin
          if ({1'b0, jp1} < {1'b0, n}) begin
            state <= S_SD_WR;
          end else begin
            n     <= n - CW'(1);
            state <= S_DONE;
          end
        end
        S_SD_WR: state <= S_SD_RD;
        S_Q_RD:  state <= (k == n) ? S_Q_PREP : S_Q_CHK;
        S_Q_CHK: state <= (qsum > tq) ? S_Q_PREP : S_Q_RD;
        S_Q_PREP: state <= S_Q_SH;
        S_Q_SH: begin
          if ((qc | qa | qd) < 64'h8000_0000) state <= S_Q_M1;
        end
        S_Q_M1:   state <= S_Q_M2;
        S_Q_M2:   state <= S_Q_DISC;
        S_Q_DISC: state <= S_Q_SQ;
        S_Q_SQ: begin
          if (sqrt_rsp.done) state <= S_Q_DEN;
        end
        S_Q_DEN: begin
          if (den != '0) begin
            state <= S_Q_DIV;
          end else begin
            state <= qazero ? S_DONE : S_Q_LERP;
          end
        end
        S_Q_DIV: begin
          if (div_rsp.done) state <= S_Q_LERP;
        end
        S_Q_LERP: state <= S_Q_FIN;
        S_Q_FIN:  state <= S_DONE;
        S_C_RD:   state <= (k == n) ? S_C_SPAN : S_C_CHK;
        S_C_CHK:  state <= (rd_data.value <= v_r) ? S_C_RD : S_C_SPAN;
        S_C_SPAN: begin
          state <= (!span[32] && span != '0) ? S_C_DIV : S_DONE;
        end
        S_C_DIV: begin
          if (div_rsp.done) state <= S_C_M1;
        end
        S_C_M1:  state <= S_C_M2;
        S_C_M2:  state <= S_C_M3;
        S_C_M3:  state <= S_C_EST;
        S_C_EST: state <= S_C_FIN;
        S_C_FIN: state <= S_DONE;
        S_DONE: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind_r  <= req.kind;
        v_r     <= vin;
        w_r     <= req.weight;
        frac_r  <= req.fraction;
        res_qv  <= '0;
        res_cnt <= '0;
        res_st  <= ST_OK;
        k       <= '0;
      end
      S_START: begin
        tq    <= 64'(frac_c * total);
        s     <= '0;
        lv    <= vmin;
        lc    <= '0;
        gbest <= '1;
        if (n == '0 && (kind_r == KIND_QUANT || kind_r == KIND_COUNT)) begin
          res_st <= ST_EMPTY;
        end else if (kind_r == KIND_COUNT && v_r >= vmax) begin
          res_cnt <= total;
        end
      end
      S_A_RD: begin
        if (k == n) begin
          pos <= n;
          j   <= n;
        end
      end
      S_A_CHK: begin
        if (rd_data.value > v_r) begin
          pos <= k;
          j   <= n;
        end else begin
          k <= k + CW'(1);
        end
      end
      S_SH_WR: j <= jm1;
      S_OV:    k <= '0;
      S_G_CHK: begin
        // strict compare keeps the lowest index on equal gaps
        if (k != '0 && gap < gbest) begin
          gbest <= gap;
          bidx  <= k - CW'(1);
        end
        gprev <= rd_data.value;
        k     <= k + CW'(1);
      end
      S_M_LO: begin
        lv <= rd_data.value;
        lc <= rd_data.count;
      end
      S_M_HI: begin
        hv   <= rd_data.value;
        hc   <= rd_data.count;
        ssum <= {1'b0, lc} + {1'b0, rd_data.count};
      end
      S_M_MUL: begin
        prod <= 64'(32'(hv - lv) * hc);
      end
      S_M_DIV: begin
        if (div_rsp.done) off <= div_rsp.quot[31:0];
      end
      S_M_WB:  j <= bidx1;
      S_SD_WR: j <= jp1;
      S_Q_RD, S_C_RD: begin
        if (k == n) begin
          hv <= vmax;
          hc <= '0;
        end
      end
      S_Q_CHK: begin
        if (qsum > tq) begin
          hv <= rd_data.value;
          hc <= rd_data.count;
        end else begin
          s  <= qsum;
          lv <= rd_data.value;
          lc <= rd_data.count;
          k  <= k + CW'(1);
        end
      end
      S_Q_PREP: begin
        qd     <= tq - s;
        qc     <= {16'b0, lc, 16'b0};
        qa     <= {15'b0, aabs, 16'b0};
        qneg   <= adiff[32];
        qazero <= (adiff == '0);
      end
      S_Q_SH: begin
        if ((qc | qa | qd) >= 64'h8000_0000) begin
          qc <= qc >> 1;
          qa <= qa >> 1;
          qd <= qd >> 1;
        end
      end
      S_Q_M1: m1 <= 64'(qc[30:0] * qc[30:0]);
      S_Q_M2: m2 <= 64'(qa[30:0] * qd[30:0]);
      S_Q_SQ: begin
        if (sqrt_rsp.done) den <= {2'b0, qc[30:0]} + {1'b0, sqrt_rsp.root};
      end
      S_Q_DEN: begin
        xz <= '0;
        if (den == '0 && qazero) begin
          res_st <= ST_DEGEN;
          res_qv <= lv;
        end
      end
      S_Q_DIV, S_C_DIV: begin
        if (div_rsp.done) begin
          xz <= (div_rsp.quot > 64'(FRAC_ONE)) ? FRAC_ONE : div_rsp.quot[16:0];
        end
      end
      S_Q_LERP: begin
        sneg <= span[32];
        prod <= 64'(span_abs * xz);
      end
      S_Q_FIN: begin
        res_qv <= sneg ? (lv - $signed(qoff[31:0])) : (lv + $signed(qoff[31:0]));
      end
      S_C_CHK: begin
        if (rd_data.value <= v_r) begin
          s  <= s + {32'b0, lc};
          lv <= rd_data.value;
          lc <= rd_data.count;
          k  <= k + CW'(1);
        end else begin
          hv <= rd_data.value;
          hc <= rd_data.count;
        end
      end
      S_C_SPAN: begin
        qa   <= {31'b0, aabs};
        qneg <= adiff[32];
        if (span[32] || span == '0) res_st <= ST_DEGEN;
      end
      S_C_M1: prod <= 64'(lc * xz);
      S_C_M2: begin
        s  <= {s[47:0], 16'b0} + {17'b0, lc, 15'b0} + prod;
        m2 <= 64'(qa[32:0] * xz);
      end
      S_C_M3: m1 <= 64'(m2[49:16] * xz);
      S_C_EST: begin
        if (qneg) begin
          s <= (s > {1'b0, m1[63:1]}) ? (s - {1'b0, m1[63:1]}) : '0;
        end else begin
          s <= s + {1'b0, m1[63:1]};
        end
      end
      S_C_FIN: begin
        res_cnt <= (est_rnd[64:48] != '0) ? 32'hFFFF_FFFF : est_rnd[47:16];
      end
      default: begin
      end
    endcase
  end

  // output register: holds one result while the next item is worked on
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_out) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_total <= total;
      o_qv    <= res_qv;
      o_cnt   <= res_cnt;
      o_st    <= res_st;
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = o_valid;
  assign rsp.total_count    = o_total;
  assign rsp.quantile_value = o_qv;
  assign rsp.count_estimate = o_cnt;
  assign rsp.status         = o_st;

endmodule
